### rtl/core/hpsg_pkg.sv
// Package for the hashed photon sample generator.
// Holds the splitmix64 mixer constants, salts and pipeline geometry.
// No dependencies.
package hpsg_pkg;

  typedef logic [63:0] word_t;

  // Mixer constants
  localparam word_t GOLDEN = 64'h9e3779b97f4a7c15;
  localparam word_t MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam word_t MUL_B  = 64'h94d049bb133111eb;

  // Operand salts
  localparam word_t IDX_SALT   = 64'h632be59bd9b4e019;
  localparam word_t DEPTH_SALT = 64'h00000000a511e9b3;

  // Fraction salts
  localparam word_t SALT_LOBE = 64'h243f6a8885a308d3;
  localparam word_t SALT_U    = 64'h13198a2e03707344;
  localparam word_t SALT_V    = 64'ha4093822299f31d0;
  localparam word_t SALT_RR   = 64'h082efa98ec4e6c89;

  // Pipeline geometry: three mixer passes of five stages each
  localparam int MIX_STAGES = 5;
  localparam int NUM_STAGES = 3 * MIX_STAGES;

  typedef logic [MIX_STAGES-1:0] mix_en_t;

endpackage

### rtl/core/hpsg_mix.sv
// Five-stage pipelined splitmix64 finalizer.
// Each 64x64 (mod 2^64) product is split into three 32x32 partial products.
// Depends on hpsg_pkg.
module hpsg_mix (
  input  logic             clk,
  input  hpsg_pkg::mix_en_t en,
  input  hpsg_pkg::word_t  x_in,
  output hpsg_pkg::word_t  x_out
);

  localparam logic [31:0] A_LO = hpsg_pkg::MUL_A[31:0];
  localparam logic [31:0] A_HI = hpsg_pkg::MUL_A[63:32];
  localparam logic [31:0] B_LO = hpsg_pkg::MUL_B[31:0];
  localparam logic [31:0] B_HI = hpsg_pkg::MUL_B[63:32];

  hpsg_pkg::word_t s0_nxt, s0_r;
  hpsg_pkg::word_t ll1_nxt, ll1_r;
  logic [31:0]     ca1_nxt, ca1_r, cb1_nxt, cb1_r;
  hpsg_pkg::word_t p2, s2_nxt, s2_r;
  hpsg_pkg::word_t ll3_nxt, ll3_r;
  logic [31:0]     ca3_nxt, ca3_r, cb3_nxt, cb3_r;
  hpsg_pkg::word_t p4, s4_nxt, s4_r;
  hpsg_pkg::word_t sum0;

  // Stage 0: add golden ratio, xorshift 30
  assign sum0   = x_in + hpsg_pkg::GOLDEN;
  assign s0_nxt = sum0 ^ (sum0 >> 30);

  // Stage 1: partial products with MUL_A
  assign ll1_nxt = s0_r[31:0] * A_LO;
  assign ca1_nxt = s0_r[63:32] * A_LO;
  assign cb1_nxt = s0_r[31:0] * A_HI;

  // Stage 2: combine, xorshift 27
  assign p2     = ll1_r + {ca1_r + cb1_r, 32'b0};
  assign s2_nxt = p2 ^ (p2 >> 27);

  // Stage 3: partial products with MUL_B
  assign ll3_nxt = s2_r[31:0] * B_LO;
  assign ca3_nxt = s2_r[63:32] * B_LO;
  assign cb3_nxt = s2_r[31:0] * B_HI;

  // Stage 4: combine, xorshift 31
  assign p4     = ll3_r + {ca3_r + cb3_r, 32'b0};
  assign s4_nxt = p4 ^ (p4 >> 31);

  // Stage registers, payload only
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
    if (en[1]) begin
      ll1_r <= ll1_nxt;
      ca1_r <= ca1_nxt;
      cb1_r <= cb1_nxt;
    end
    if (en[2]) begin
      s2_r <= s2_nxt;
    end
    if (en[3]) begin
      ll3_r <= ll3_nxt;
      ca3_r <= ca3_nxt;
      cb3_r <= cb3_nxt;
    end
    if (en[4]) begin
      s4_r <= s4_nxt;
    end
  end

  assign x_out = s4_r;

endmodule

### rtl/core/hashed_photon_sample_generator_top.sv
// Top level of the hashed photon sample generator.
// Instantiates nine hpsg_mix finalizer pipelines; depends on hpsg_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries photon id, sample index, seed and
//   bounce depth. Output channel out_valid/out_ready carries one result per
//   request: valid flag, folded base seed, four 53-bit unit fractions and the
//   echoed depth. A zero depth gives a result with every field zero.
// Timing:
//   Fifteen register stages: three mixer passes (operand mix, key mix,
//   fraction mix) of five stages each, each 64-bit product split into 32x32
//   partial products with a register after the multipliers.
//   Throughput is one request per cycle while out_ready does not stall the pipe.
// Flow control:
//   Every stage holds a valid bit and moves when it is empty or the stage
//   after it moves, so bubbles close up. When the receiver stalls, results
//   hold in place and requests keep entering until the pipe is full.
// Reset:
//   rst_n (synchronous, active low) clears all valid bits; payload registers
//   are not reset.
module hashed_photon_sample_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_photon_id,
  input  logic [63:0] in_sample_index,
  input  logic [31:0] in_seed_word,
  input  logic [31:0] in_bounce_depth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sample_valid,
  output logic [31:0] out_base_seed,
  output logic [52:0] out_lobe_fraction,
  output logic [52:0] out_dir_u_fraction,
  output logic [52:0] out_dir_v_fraction,
  output logic [52:0] out_roulette_fraction,
  output logic [31:0] out_depth_echo
);

  localparam int NS = hpsg_pkg::NUM_STAGES;
  localparam int MS = hpsg_pkg::MIX_STAGES;

  logic [NS-1:0]   v_r;
  logic [NS-1:0]   en;
  logic [31:0]     depth_r [NS];
  hpsg_pkg::word_t key_r   [MS];

  hpsg_pkg::mix_en_t en_op, en_key, en_frac;
  hpsg_pkg::word_t   m_pid, m_idx, m_seed, m_depth;
  hpsg_pkg::word_t   key_in, key;
  hpsg_pkg::word_t   f_lobe, f_u, f_v, f_rr;
  hpsg_pkg::word_t   key_fold;
  logic              nz;

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS-1] = ~v_r[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  assign in_ready = en[0];
  assign en_op    = en[MS-1:0];
  assign en_key   = en[2*MS-1:MS];
  assign en_frac  = en[3*MS-1:2*MS];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Depth sideband across all stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      depth_r[0] <= in_bounce_depth;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        depth_r[k] <= depth_r[k-1];
      end
    end
  end

  // Operand mix pass
  hpsg_mix u_mix_pid (
    .clk(clk), .en(en_op), .x_in(in_photon_id), .x_out(m_pid)
  );
  hpsg_mix u_mix_idx (
    .clk(clk), .en(en_op), .x_in(in_sample_index ^ hpsg_pkg::IDX_SALT), .x_out(m_idx)
  );
  hpsg_mix u_mix_seed (
    .clk(clk), .en(en_op), .x_in({in_seed_word, 32'b0}), .x_out(m_seed)
  );
  hpsg_mix u_mix_depth (
    .clk(clk), .en(en_op), .x_in({32'b0, in_bounce_depth} ^ hpsg_pkg::DEPTH_SALT),
    .x_out(m_depth)
  );

  // Key mix pass
  assign key_in = m_pid ^ m_idx ^ m_seed ^ m_depth;

  hpsg_mix u_mix_key (
    .clk(clk), .en(en_key), .x_in(key_in), .x_out(key)
  );

  // Key sideband through the fraction pass
  always_ff @(posedge clk) begin
    if (en_frac[0]) begin
      key_r[0] <= key;
    end
    for (int k = 1; k < MS; k++) begin
      if (en_frac[k]) begin
        key_r[k] <= key_r[k-1];
      end
    end
  end

  // Fraction mix pass
  hpsg_mix u_mix_lobe (
    .clk(clk), .en(en_frac), .x_in(key ^ hpsg_pkg::SALT_LOBE), .x_out(f_lobe)
  );
  hpsg_mix u_mix_u (
    .clk(clk), .en(en_frac), .x_in(key ^ hpsg_pkg::SALT_U), .x_out(f_u)
  );
  hpsg_mix u_mix_v (
    .clk(clk), .en(en_frac), .x_in(key ^ hpsg_pkg::SALT_V), .x_out(f_v)
  );
  hpsg_mix u_mix_rr (
    .clk(clk), .en(en_frac), .x_in(key ^ hpsg_pkg::SALT_RR), .x_out(f_rr)
  );

  // Output: zero depth forces every field to zero
  assign nz       = |depth_r[NS-1];
  assign key_fold = key_r[MS-1] ^ (key_r[MS-1] >> 32);

  assign out_valid             = v_r[NS-1];
  assign out_sample_valid      = nz;
  assign out_base_seed         = nz ? key_fold[31:0] : 32'b0;
  assign out_lobe_fraction     = nz ? f_lobe[63:11] : 53'b0;
  assign out_dir_u_fraction    = nz ? f_u[63:11] : 53'b0;
  assign out_dir_v_fraction    = nz ? f_v[63:11] : 53'b0;
  assign out_roulette_fraction = nz ? f_rr[63:11] : 53'b0;
  assign out_depth_echo        = depth_r[NS-1];

endmodule
